// ----- design/sic_pkg.sv -----
// Shared types, constants and helper functions for the safety interlock sweep controller.
// Every design file and the checker import this package; it depends on nothing else.
`default_nettype none

package sic_pkg;

   localparam int CMD_W       = 2;
   localparam int ECHO_W      = 16;
   localparam int PRESS_W     = 40;
   localparam int THRESH_W    = 10;
   localparam int DEBOUNCE_W  = 24;
   localparam int TIMEOUT_W   = 16;
   localparam int STEP_W      = 7;
   localparam int RANGE_W     = 11;
   localparam int ANGLE_W     = 8;
   localparam int MODE_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam int SWEEP_MAX_DEG_DEFAULT = 180;
   localparam int DUTY_BITS_DEFAULT     = 13;

   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RANGE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PRESS = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BREACH_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE         = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ECHO_TIMEOUT     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWEEP_STEP       = 2'd3;

   localparam logic [THRESH_W-1:0]   THRESH_RESET   = 10'd200;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 24'd200000;
   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 16'd30000;
   localparam logic [STEP_W-1:0]     STEP_RESET     = 7'd2;

   localparam logic [MODE_W-1:0] MODE_CODE_RUN     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CODE_BREACH  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CODE_ARM_OFF = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CODE_WAIT    = 2'd3;

   // The range is floor(echo * 343 / 20000). Multiplying by the rounded-up
   // reciprocal scaled by 2^31 gives the exact floor for every 16-bit echo.
   localparam int                RANGE_K_W   = 26;
   localparam logic [RANGE_K_W-1:0] RANGE_K  = 26'd36829345;
   localparam int                RANGE_SHIFT = 31;
   localparam int                PROD_W      = ECHO_W + RANGE_K_W;
   localparam logic [RANGE_W-1:0] RANGE_MAX  = 11'd1023;
   localparam logic signed [RANGE_W-1:0] RANGE_NONE = -11'sd1;

   localparam int DUTY_AT_ZERO  = 205;
   localparam int DUTY_AT_FULL  = 983;
   localparam int DUTY_SPAN_DEG = 180;
   localparam int ANGLE_COUNT   = 1 << ANGLE_W;

   typedef enum logic [3:0] {
      MODE_RUN     = 4'b0001,
      MODE_BREACH  = 4'b0010,
      MODE_ARM_OFF = 4'b0100,
      MODE_WAIT    = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [THRESH_W-1:0]   breach_threshold_cm;
      logic [DEBOUNCE_W-1:0] debounce_us;
      logic [TIMEOUT_W-1:0]  echo_timeout_us;
      logic [STEP_W-1:0]     sweep_step_deg;
   } cfg_type;

   function automatic logic [MODE_W-1:0] mode_code(input mode_type mode);
      logic [MODE_W-1:0] code;
      unique case (mode)
         MODE_RUN:     code = MODE_CODE_RUN;
         MODE_BREACH:  code = MODE_CODE_BREACH;
         MODE_ARM_OFF: code = MODE_CODE_ARM_OFF;
         MODE_WAIT:    code = MODE_CODE_WAIT;
         default:      code = MODE_CODE_ARM_OFF;
      endcase
      return code;
   endfunction

   // Evaluated only at elaboration to fill the angle-to-duty table.
   function automatic int duty_of_angle(input int angle, input int duty_bits);
      int duty;
      int top;
      duty = DUTY_AT_ZERO + angle * (DUTY_AT_FULL - DUTY_AT_ZERO) / DUTY_SPAN_DEG;
      top  = (1 << duty_bits) - 1;
      return (duty > top) ? top : duty;
   endfunction

endpackage

`default_nettype wire

// ----- design/sic_csr.sv -----
// Configuration register file of the safety interlock sweep controller.
// Depends on sic_pkg for the register indexes, widths and reset values.
`default_nettype none

module sic_csr
   import sic_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BREACH_THRESHOLD: cfg_in.breach_threshold_cm = csr_data[THRESH_W-1:0];
            CSR_DEBOUNCE:         cfg_in.debounce_us         = csr_data[DEBOUNCE_W-1:0];
            CSR_ECHO_TIMEOUT:     cfg_in.echo_timeout_us     = csr_data[TIMEOUT_W-1:0];
            CSR_SWEEP_STEP:       cfg_in.sweep_step_deg      = csr_data[STEP_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.breach_threshold_cm <= THRESH_RESET;
         cfg_ff.debounce_us         <= DEBOUNCE_RESET;
         cfg_ff.echo_timeout_us     <= TIMEOUT_RESET;
         cfg_ff.sweep_step_deg      <= STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/sic_range_calc.sv -----
// Echo width to range conversion with timeout and breach detection.
// Depends on sic_pkg for the fixed-point reciprocal and field widths.
`default_nettype none

module sic_range_calc
   import sic_pkg::*;
(
   input  wire logic [ECHO_W-1:0]    echo_width_us,
   input  wire logic                 echo_missing,
   input  wire logic [TIMEOUT_W-1:0] echo_timeout_us,
   input  wire logic [THRESH_W-1:0]  breach_threshold_cm,
   output logic                      timed_out,
   output logic [RANGE_W-1:0]        range_cm,
   output logic                      breach
);

   logic [PROD_W-1:0]  product;
   logic [RANGE_W-1:0] quotient;

   assign product   = PROD_W'(echo_width_us) * PROD_W'(RANGE_K);
   assign quotient  = product[RANGE_SHIFT +: RANGE_W];
   assign timed_out = echo_missing || (echo_width_us > echo_timeout_us);
   assign range_cm  = (quotient > RANGE_MAX) ? RANGE_MAX : quotient;
   assign breach    = (range_cm != '0) && (range_cm < {1'b0, breach_threshold_cm});

endmodule

`default_nettype wire

// ----- design/sic_sweep_step.sv -----
// Servo sweep stepping with bounce at both ends, and the angle-to-duty table.
// Depends on sic_pkg for widths and the duty mapping function.
`default_nettype none

module sic_sweep_step
   import sic_pkg::*;
#(
   parameter int SWEEP_MAX_DEG = SWEEP_MAX_DEG_DEFAULT,
   parameter int DUTY_BITS     = DUTY_BITS_DEFAULT
) (
   input  wire logic [ANGLE_W-1:0] pos,
   input  wire logic               dir_down,
   input  wire logic [STEP_W-1:0]  step,
   output logic [ANGLE_W-1:0]      pos_next,
   output logic                    dir_down_next,
   output logic [DUTY_BITS-1:0]    duty_next
);

   localparam int SUM_W = ANGLE_W + 2;

   logic signed [SUM_W-1:0] moved_pos;
   logic [DUTY_BITS-1:0]    duty_lut [ANGLE_COUNT];

   for (genvar g = 0; g < ANGLE_COUNT; g++) begin : g_duty_lut
      assign duty_lut[g] = DUTY_BITS'(duty_of_angle(g, DUTY_BITS));
   end

   always_comb begin
      if (dir_down) begin
         moved_pos = $signed(SUM_W'(pos)) - $signed(SUM_W'(step));
      end else begin
         moved_pos = $signed(SUM_W'(pos)) + $signed(SUM_W'(step));
      end
      pos_next      = moved_pos[ANGLE_W-1:0];
      dir_down_next = dir_down;
      if (moved_pos >= $signed(SUM_W'(SWEEP_MAX_DEG))) begin
         pos_next      = ANGLE_W'(SWEEP_MAX_DEG);
         dir_down_next = 1'b1;
      end else if (moved_pos <= $signed(SUM_W'(0))) begin
         pos_next      = '0;
         dir_down_next = 1'b0;
      end
   end

   assign duty_next = duty_lut[pos_next];

endmodule

`default_nettype wire

// ----- design/safety_interlock_sweep_controller_top.sv -----
// Top level of the safety interlock sweep controller: input register, lockout state,
// result register. Depends on sic_pkg, sic_csr, sic_range_calc and sic_sweep_step.
//
//   channel   prefix  direction  contents
//   request   req_    in         cmd, arm switch, echo width, echo missing, press time
//   response  rsp_    out        mode, lamps, alarm, range, fouled, angle, duty, written
//   config    csr_    in         register index and write data, always ready
//
// An item is held in the input register; the lockout, range and sweep logic then writes
// its result into the output register, and one item is taken every cycle while the
// response side keeps up.
// A stalled response holds the input register; the request side then stalls one item later.
// Reset is synchronous and restores the lockout state and valid flags, not the result fields.
`default_nettype none

module safety_interlock_sweep_controller_top
   import sic_pkg::*;
#(
   parameter int SWEEP_MAX_DEG = SWEEP_MAX_DEG_DEFAULT,
   parameter int DUTY_BITS     = DUTY_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [CMD_W-1:0]       req_cmd,
   input  wire logic                   req_arm_switch,
   input  wire logic [ECHO_W-1:0]      req_echo_width_us,
   input  wire logic                   req_echo_missing,
   input  wire logic [PRESS_W-1:0]     req_press_time_us,

   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [MODE_W-1:0]           rsp_mode,
   output logic                        rsp_fault_lamp,
   output logic                        rsp_active_lamp,
   output logic                        rsp_alarm_on,
   output logic signed [RANGE_W-1:0]   rsp_range_cm,
   output logic                        rsp_zone_fouled,
   output logic [ANGLE_W-1:0]          rsp_servo_angle,
   output logic [DUTY_BITS-1:0]        rsp_servo_duty,
   output logic                        rsp_duty_written,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg;

   logic                 in_valid_ff, in_valid_in;
   logic [CMD_W-1:0]     cmd_ff;
   logic                 arm_ff;
   logic [ECHO_W-1:0]    echo_ff;
   logic                 missing_ff;
   logic [PRESS_W-1:0]   press_ff;

   mode_type             mode_ff, mode_in;
   logic                 fault_ff, fault_in;
   logic                 active_ff, active_in;
   logic                 breach_pend_ff, breach_pend_in;
   logic                 reset_pend_ff, reset_pend_in;
   logic                 fouled_ff, fouled_in;
   logic                 prior_breach_ff, prior_breach_in;
   logic signed [RANGE_W-1:0] range_ff, range_in;
   logic [ANGLE_W-1:0]   pos_ff, pos_in;
   logic                 dir_down_ff, dir_down_in;
   logic [DUTY_BITS-1:0] duty_ff, duty_in;
   logic [PRESS_W-1:0]   last_press_ff, last_press_in;
   logic                 moved;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MODE_W-1:0]    rsp_mode_ff;
   logic                 rsp_fault_ff, rsp_active_ff, rsp_alarm_ff, rsp_fouled_ff;
   logic signed [RANGE_W-1:0] rsp_range_ff;
   logic [ANGLE_W-1:0]   rsp_angle_ff;
   logic [DUTY_BITS-1:0] rsp_duty_ff;
   logic                 rsp_written_ff;

   logic                 advance;
   logic                 req_accept;

   logic                 timed_out;
   logic [RANGE_W-1:0]   calc_range;
   logic                 calc_breach;
   logic [ANGLE_W-1:0]   sweep_pos_next;
   logic                 sweep_dir_next;
   logic [DUTY_BITS-1:0] sweep_duty_next;
   logic [PRESS_W-1:0]   press_delta;

   sic_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sic_range_calc u_range (
      .echo_width_us       (echo_ff),
      .echo_missing        (missing_ff),
      .echo_timeout_us     (cfg.echo_timeout_us),
      .breach_threshold_cm (cfg.breach_threshold_cm),
      .timed_out           (timed_out),
      .range_cm            (calc_range),
      .breach              (calc_breach)
   );

   sic_sweep_step #(
      .SWEEP_MAX_DEG (SWEEP_MAX_DEG),
      .DUTY_BITS     (DUTY_BITS)
   ) u_sweep (
      .pos           (pos_ff),
      .dir_down      (dir_down_ff),
      .step          (cfg.sweep_step_deg),
      .pos_next      (sweep_pos_next),
      .dir_down_next (sweep_dir_next),
      .duty_next     (sweep_duty_next)
   );

   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign req_accept  = req_valid && req_ready;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);
   assign press_delta = press_ff - last_press_ff;

   always_comb begin
      mode_in         = mode_ff;
      fault_in        = fault_ff;
      active_in       = active_ff;
      breach_pend_in  = breach_pend_ff;
      reset_pend_in   = reset_pend_ff;
      fouled_in       = fouled_ff;
      prior_breach_in = prior_breach_ff;
      range_in        = range_ff;
      pos_in          = pos_ff;
      dir_down_in     = dir_down_ff;
      duty_in         = duty_ff;
      last_press_in   = last_press_ff;
      moved           = 1'b0;
      if (advance) begin
         unique case (cmd_ff)
            CMD_TICK: begin
               if (!arm_ff) begin
                  mode_in       = MODE_ARM_OFF;
                  fault_in      = 1'b1;
                  active_in     = 1'b0;
                  reset_pend_in = 1'b0;
               end else begin
                  if (mode_in == MODE_ARM_OFF) begin
                     mode_in = MODE_WAIT;
                  end
                  if (breach_pend_ff) begin
                     breach_pend_in = 1'b0;
                     mode_in        = MODE_BREACH;
                     fault_in       = 1'b1;
                     active_in      = 1'b0;
                  end
                  if (reset_pend_ff) begin
                     reset_pend_in = 1'b0;
                     if ((mode_in == MODE_BREACH || mode_in == MODE_WAIT) && !fouled_ff) begin
                        mode_in   = MODE_RUN;
                        fault_in  = 1'b0;
                        active_in = 1'b1;
                     end
                  end
                  if (mode_in == MODE_BREACH && !fouled_ff) begin
                     mode_in = MODE_WAIT;
                  end
                  if (mode_in == MODE_RUN) begin
                     pos_in      = sweep_pos_next;
                     dir_down_in = sweep_dir_next;
                     duty_in     = sweep_duty_next;
                     moved       = 1'b1;
                  end
               end
            end
            CMD_RANGE: begin
               if (timed_out) begin
                  fouled_in = 1'b1;
                  range_in  = RANGE_NONE;
               end else begin
                  range_in        = $signed(calc_range);
                  fouled_in       = calc_breach;
                  prior_breach_in = calc_breach;
                  if (calc_breach && !prior_breach_ff) begin
                     breach_pend_in = 1'b1;
                  end
               end
            end
            CMD_PRESS: begin
               if (press_ff > last_press_ff && press_delta > PRESS_W'(cfg.debounce_us)) begin
                  last_press_in = press_ff;
                  reset_pend_in = 1'b1;
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         mode_ff         <= MODE_ARM_OFF;
         fault_ff        <= 1'b0;
         active_ff       <= 1'b0;
         breach_pend_ff  <= 1'b0;
         reset_pend_ff   <= 1'b0;
         fouled_ff       <= 1'b0;
         prior_breach_ff <= 1'b0;
         range_ff        <= RANGE_NONE;
         pos_ff          <= '0;
         dir_down_ff     <= 1'b0;
         duty_ff         <= '0;
         last_press_ff   <= '0;
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         mode_ff         <= mode_in;
         fault_ff        <= fault_in;
         active_ff       <= active_in;
         breach_pend_ff  <= breach_pend_in;
         reset_pend_ff   <= reset_pend_in;
         fouled_ff       <= fouled_in;
         prior_breach_ff <= prior_breach_in;
         range_ff        <= range_in;
         pos_ff          <= pos_in;
         dir_down_ff     <= dir_down_in;
         duty_ff         <= duty_in;
         last_press_ff   <= last_press_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff     <= req_cmd;
         arm_ff     <= req_arm_switch;
         echo_ff    <= req_echo_width_us;
         missing_ff <= req_echo_missing;
         press_ff   <= req_press_time_us;
      end
      if (advance) begin
         rsp_mode_ff    <= mode_code(mode_in);
         rsp_fault_ff   <= fault_in;
         rsp_active_ff  <= active_in;
         rsp_alarm_ff   <= (mode_in == MODE_BREACH);
         rsp_range_ff   <= range_in;
         rsp_fouled_ff  <= fouled_in;
         rsp_angle_ff   <= pos_in;
         rsp_duty_ff    <= duty_in;
         rsp_written_ff <= moved;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mode         = rsp_mode_ff;
   assign rsp_fault_lamp   = rsp_fault_ff;
   assign rsp_active_lamp  = rsp_active_ff;
   assign rsp_alarm_on     = rsp_alarm_ff;
   assign rsp_range_cm     = rsp_range_ff;
   assign rsp_zone_fouled  = rsp_fouled_ff;
   assign rsp_servo_angle  = rsp_angle_ff;
   assign rsp_servo_duty   = rsp_duty_ff;
   assign rsp_duty_written = rsp_written_ff;

endmodule

`default_nettype wire

// ----- design/sic_checker.sv -----
// Port-level assertions for the safety interlock sweep controller and their bind.
// Depends on sic_pkg for the mode codes; attaches to the top level.
`default_nettype none

module sic_checker
   import sic_pkg::*;
#(
   parameter int SWEEP_MAX_DEG = SWEEP_MAX_DEG_DEFAULT,
   parameter int DUTY_BITS     = DUTY_BITS_DEFAULT
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [MODE_W-1:0]    rsp_mode,
   input wire logic                 rsp_fault_lamp,
   input wire logic                 rsp_active_lamp,
   input wire logic                 rsp_alarm_on,
   input wire logic [ANGLE_W-1:0]   rsp_servo_angle,
   input wire logic [DUTY_BITS-1:0] rsp_servo_duty,
   input wire logic                 rsp_duty_written
);

   // The alarm follows the breach mode exactly.
   a_alarm_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alarm_on == (rsp_mode == MODE_CODE_BREACH)))
      else $error("alarm does not match breach mode");

   // While operational the lamps show active and no fault.
   a_run_lamps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mode == MODE_CODE_RUN) |-> (rsp_active_lamp && !rsp_fault_lamp))
      else $error("lamps inconsistent with operational mode");

   // The servo moves only when the lockout is operational and stays in its sector.
   a_move_in_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_duty_written) |->
         (rsp_mode == MODE_CODE_RUN && rsp_servo_angle <= ANGLE_W'(SWEEP_MAX_DEG)))
      else $error("servo moved outside operational mode or sector");

   // A stalled result transfer stays valid and holds its mode and duty.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_mode) && $stable(rsp_servo_duty)))
      else $error("stalled result changed");

endmodule

bind safety_interlock_sweep_controller_top sic_checker #(
   .SWEEP_MAX_DEG (SWEEP_MAX_DEG),
   .DUTY_BITS     (DUTY_BITS)
) u_sic_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_mode         (rsp_mode),
   .rsp_fault_lamp   (rsp_fault_lamp),
   .rsp_active_lamp  (rsp_active_lamp),
   .rsp_alarm_on     (rsp_alarm_on),
   .rsp_servo_angle  (rsp_servo_angle),
   .rsp_servo_duty   (rsp_servo_duty),
   .rsp_duty_written (rsp_duty_written)
);

`default_nettype wire

// ----- bench/safety_interlock_sweep_controller_top_tb.sv -----
// Self-checking testbench for safety_interlock_sweep_controller_top. It predicts each status
// transfer from its own model of the guard lockout, range and sweep logic. Depends on sic_pkg.
`timescale 1ns / 100ps

module safety_interlock_sweep_controller_top_tb
   import sic_pkg::*;
();

   localparam int DUTY_BITS      = DUTY_BITS_DEFAULT;
   localparam int SWEEP_MAX      = SWEEP_MAX_DEG_DEFAULT;
   localparam int STALL_LIMIT    = 2000;

   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic                      fault_lamp;
      logic                      active_lamp;
      logic                      alarm_on;
      logic signed [RANGE_W-1:0] range_cm;
      logic                      zone_fouled;
      logic [ANGLE_W-1:0]        servo_angle;
      logic [DUTY_BITS-1:0]      servo_duty;
      logic                      duty_written;
   } status_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [CMD_W-1:0]            req_cmd = CMD_TICK;
   logic                        req_arm_switch = 1'b0;
   logic [ECHO_W-1:0]           req_echo_width_us = '0;
   logic                        req_echo_missing = 1'b0;
   logic [PRESS_W-1:0]          req_press_time_us = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b1;
   logic [MODE_W-1:0]           rsp_mode;
   logic                        rsp_fault_lamp;
   logic                        rsp_active_lamp;
   logic                        rsp_alarm_on;
   logic signed [RANGE_W-1:0]   rsp_range_cm;
   logic                        rsp_zone_fouled;
   logic [ANGLE_W-1:0]          rsp_servo_angle;
   logic [DUTY_BITS-1:0]        rsp_servo_duty;
   logic                        rsp_duty_written;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index = CSR_BREACH_THRESHOLD;
   logic [CSR_DATA_W-1:0]       csr_data = '0;

   // Predicted state of the interlock and its registers.
   logic [MODE_W-1:0]   lock_mode;
   logic                fault_lit;
   logic                scan_lit;
   logic                breach_latched;
   logic                rearm_latched;
   logic                zone_blocked;
   logic                last_was_breach;
   int                  range_now;
   int                  angle_now;
   logic                sweeping_down;
   int                  duty_now;
   logic [PRESS_W-1:0]  last_stamp;
   logic [THRESH_W-1:0]   thresh_cm;
   logic [DEBOUNCE_W-1:0] debounce_span;
   logic [TIMEOUT_W-1:0]  echo_limit;
   logic [STEP_W-1:0]     step_deg;

   status_type status_queue[$];
   bit      idle_on = 1'b0;
   int      stall_left = 0;
   int      error_count = 0;
   int      items_sent = 0;
   int      responses_seen = 0;
   int      servo_moves = 0;
   int      settings_used = 0;
   int      mode_seen[4] = '{0, 0, 0, 0};
   int      quiet_cycles = 0;

   safety_interlock_sweep_controller_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_arm_switch    (req_arm_switch),
      .req_echo_width_us (req_echo_width_us),
      .req_echo_missing  (req_echo_missing),
      .req_press_time_us (req_press_time_us),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mode          (rsp_mode),
      .rsp_fault_lamp    (rsp_fault_lamp),
      .rsp_active_lamp   (rsp_active_lamp),
      .rsp_alarm_on      (rsp_alarm_on),
      .rsp_range_cm      (rsp_range_cm),
      .rsp_zone_fouled   (rsp_zone_fouled),
      .rsp_servo_angle   (rsp_servo_angle),
      .rsp_servo_duty    (rsp_servo_duty),
      .rsp_duty_written  (rsp_duty_written),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      lock_mode       = MODE_CODE_ARM_OFF;
      fault_lit       = 1'b0;
      scan_lit        = 1'b0;
      breach_latched  = 1'b0;
      rearm_latched   = 1'b0;
      zone_blocked    = 1'b0;
      last_was_breach = 1'b0;
      range_now       = -1;
      angle_now       = 0;
      sweeping_down   = 1'b0;
      duty_now        = 0;
      last_stamp      = '0;
      thresh_cm       = THRESH_RESET;
      debounce_span   = DEBOUNCE_RESET;
      echo_limit      = TIMEOUT_RESET;
      step_deg        = STEP_RESET;
   end

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic string show_status(input status_type s);
      return $sformatf({"mode=%0d fault=%0b active=%0b alarm=%0b range=%0d fouled=%0b ",
                        "angle=%0d duty=%0d moved=%0b"},
                       s.mode, s.fault_lamp, s.active_lamp, s.alarm_on, s.range_cm,
                       s.zone_fouled, s.servo_angle, s.servo_duty, s.duty_written);
   endfunction

   // Advances the predicted interlock by one accepted request and queues its status.
   task automatic predict_status(input logic [CMD_W-1:0] cmd, input logic arm,
                                 input logic [ECHO_W-1:0] echo, input logic missing,
                                 input logic [PRESS_W-1:0] stamp);
      status_type        s;
      logic              moved;
      logic              breach;
      longint unsigned   span_cm;
      moved = 1'b0;
      case (cmd)
         CMD_TICK: begin
            if (!arm) begin
               lock_mode     = MODE_CODE_ARM_OFF;
               fault_lit     = 1'b1;
               scan_lit      = 1'b0;
               rearm_latched = 1'b0;
            end else begin
               if (lock_mode == MODE_CODE_ARM_OFF) lock_mode = MODE_CODE_WAIT;
               if (breach_latched) begin
                  breach_latched = 1'b0;
                  lock_mode      = MODE_CODE_BREACH;
                  fault_lit      = 1'b1;
                  scan_lit       = 1'b0;
               end
               if (rearm_latched) begin
                  rearm_latched = 1'b0;
                  if ((lock_mode == MODE_CODE_BREACH || lock_mode == MODE_CODE_WAIT) &&
                      !zone_blocked) begin
                     lock_mode = MODE_CODE_RUN;
                     fault_lit = 1'b0;
                     scan_lit  = 1'b1;
                  end
               end
               if (lock_mode == MODE_CODE_BREACH && !zone_blocked)
                  lock_mode = MODE_CODE_WAIT;
            end
            if (lock_mode == MODE_CODE_RUN && arm) begin
               angle_now = sweeping_down ? angle_now - int'(step_deg)
                                         : angle_now + int'(step_deg);
               if (angle_now >= SWEEP_MAX) begin
                  angle_now     = SWEEP_MAX;
                  sweeping_down = 1'b1;
               end else if (angle_now <= 0) begin
                  angle_now     = 0;
                  sweeping_down = 1'b0;
               end
               duty_now = DUTY_AT_ZERO +
                          angle_now * (DUTY_AT_FULL - DUTY_AT_ZERO) / DUTY_SPAN_DEG;
               if (duty_now > (1 << DUTY_BITS) - 1) duty_now = (1 << DUTY_BITS) - 1;
               moved = 1'b1;
            end
         end
         CMD_RANGE: begin
            if (missing || echo > echo_limit) begin
               zone_blocked = 1'b1;
               range_now    = -1;
            end else begin
               span_cm = (longint'(echo) * 343) / 20000;
               if (span_cm > 1023) span_cm = 1023;
               range_now    = int'(span_cm);
               breach       = span_cm > 0 && span_cm < thresh_cm;
               zone_blocked = breach;
               if (breach && !last_was_breach) breach_latched = 1'b1;
               last_was_breach = breach;
            end
         end
         CMD_PRESS: begin
            if (stamp > last_stamp && stamp - last_stamp > debounce_span) begin
               last_stamp    = stamp;
               rearm_latched = 1'b1;
            end
         end
         default: ;
      endcase
      s.mode         = lock_mode;
      s.fault_lamp   = fault_lit;
      s.active_lamp  = scan_lit;
      s.alarm_on     = lock_mode == MODE_CODE_BREACH;
      s.range_cm     = range_now[RANGE_W-1:0];
      s.zone_fouled  = zone_blocked;
      s.servo_angle  = angle_now[ANGLE_W-1:0];
      s.servo_duty   = duty_now[DUTY_BITS-1:0];
      s.duty_written = moved;
      status_queue.push_back(s);
   endtask

   function automatic logic [PRESS_W-1:0] rand_stamp();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[PRESS_W-1:0];
   endfunction

   function automatic logic [ECHO_W-1:0] rand_echo();
      logic [31:0] w;
      w = $urandom;
      return w[ECHO_W-1:0];
   endfunction

   // An echo that reads at or above the threshold, or reads zero when that cannot be had.
   function automatic logic [ECHO_W-1:0] clear_echo();
      int need;
      int top;
      logic [31:0] w;
      need = (int'(thresh_cm) * 20000 + 342) / 343;
      top  = int'(echo_limit);
      if (need <= top) w = $urandom_range(need, (need + 2000 < top) ? need + 2000 : top);
      else w = $urandom_range(0, (top < 58) ? top : 58);
      return w[ECHO_W-1:0];
   endfunction

   function automatic logic [ECHO_W-1:0] breach_echo();
      int r;
      logic [31:0] w;
      if (thresh_cm < 2) return rand_echo();
      r = $urandom_range(1, int'(thresh_cm) - 1);
      w = (r * 20000 + 342) / 343;
      return w[ECHO_W-1:0];
   endfunction

   function automatic logic [ECHO_W-1:0] any_echo();
      logic [31:0] w;
      if ($urandom_range(0, 1) == 0) return rand_echo();
      w = $urandom_range(0, (int'(echo_limit) + 100 > 65535) ? 65535 : int'(echo_limit) + 100);
      return w[ECHO_W-1:0];
   endfunction

   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic arm,
                               input logic [ECHO_W-1:0] echo, input logic missing,
                               input logic [PRESS_W-1:0] stamp);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_arm_switch    <= arm;
      req_echo_width_us <= echo;
      req_echo_missing  <= missing;
      req_press_time_us <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_status(cmd, arm, echo, missing, stamp);
      items_sent++;
   endtask

   task automatic send_tick(input logic arm);
      send_request(CMD_TICK, arm, rand_echo(), 1'($urandom_range(0, 1)), rand_stamp());
   endtask

   task automatic send_range(input logic [ECHO_W-1:0] echo, input logic missing);
      send_request(CMD_RANGE, 1'($urandom_range(0, 1)), echo, missing, rand_stamp());
   endtask

   task automatic send_press(input logic [PRESS_W-1:0] stamp);
      send_request(CMD_PRESS, 1'($urandom_range(0, 1)), rand_echo(),
                   1'($urandom_range(0, 1)), stamp);
   endtask

   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (status_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_BREACH_THRESHOLD: thresh_cm     = value[THRESH_W-1:0];
         CSR_DEBOUNCE:         debounce_span = value[DEBOUNCE_W-1:0];
         CSR_ECHO_TIMEOUT:     echo_limit    = value[TIMEOUT_W-1:0];
         CSR_SWEEP_STEP:       step_deg      = value[STEP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input int thr, input int deb, input int tmo, input int step);
      write_register(CSR_BREACH_THRESHOLD, CSR_DATA_W'(thr));
      write_register(CSR_DEBOUNCE, CSR_DATA_W'(deb));
      write_register(CSR_ECHO_TIMEOUT, CSR_DATA_W'(tmo));
      write_register(CSR_SWEEP_STEP, CSR_DATA_W'(step));
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   // Mostly well-formed recover-and-sweep and breach sequences, with some noise.
   task automatic stream_sequences(input int target);
      int first;
      int kind;
      int n;
      logic [CMD_W-1:0] cmd;
      logic [PRESS_W-1:0] stamp;
      first = items_sent;
      while (items_sent - first < target) begin
         kind = $urandom_range(0, 9);
         if (kind <= 4) begin
            send_range(clear_echo(), 1'b0);
            send_press(last_stamp + debounce_span + $urandom_range(1, 3000));
            send_tick(1'b1);
            n = $urandom_range(2, 12);
            for (int j = 0; j < n; j++) begin
               if ($urandom_range(0, 5) == 0) send_range(any_echo(), $urandom_range(0, 9) == 0);
               else send_tick($urandom_range(0, 15) != 0);
            end
         end else if (kind <= 6) begin
            send_range(breach_echo(), 1'b0);
            send_tick(1'b1);
            send_tick(1'b1);
            send_range(clear_echo(), 1'b0);
            send_tick(1'b1);
         end else begin
            cmd = CMD_W'($urandom_range(0, 3));
            stamp = rand_stamp();
            if (cmd == CMD_PRESS) begin
               if (last_stamp > 5000 && $urandom_range(0, 2) == 0)
                  stamp = last_stamp - $urandom_range(0, 5000);
               else
                  stamp = last_stamp + $urandom_range(0, 2 * int'(debounce_span) + 16);
            end
            send_request(cmd, 1'($urandom_range(0, 1)), any_echo(),
                         1'($urandom_range(0, 1)), stamp);
         end
      end
   endtask

   task automatic test_power_on_status();
      send_request(CMD_UNKNOWN, 1'b1, rand_echo(), 1'b1, rand_stamp());
      send_range(16'd0, 1'b0);
      send_tick(1'b0);
   endtask

   task automatic test_lockout_sequence();
      send_tick(1'b1);
      send_press(40'd0);
      send_press(40'd150000);
      send_press(40'd250000);
      send_tick(1'b1);
      send_range(16'd5000, 1'b0);
      send_tick(1'b1);
      send_range(16'd20000, 1'b0);
      send_tick(1'b1);
      send_press(40'd450000);
      send_press(40'd450001);
      send_tick(1'b1);
      send_range(16'd100, 1'b1);
      send_range(16'd30001, 1'b0);
      send_range(16'd30000, 1'b0);
      send_tick(1'b0);
   endtask

   task automatic test_register_extremes();
      settle_pipeline();
      configure(0, 0, 16'hFFFF, 0);
      send_range(16'hFFFF, 1'b0);
      send_tick(1'b1);
      send_press(last_stamp + 40'd1);
      send_tick(1'b1);
      send_tick(1'b1);
      settle_pipeline();
      configure(1023, 24'hFFFFFF, 0, 127);
      send_range(16'd1, 1'b0);
      send_range(16'd0, 1'b0);
      send_press(last_stamp + 40'h1000000);
      for (int k = 0; k < 4; k++) send_tick(1'b1);
   endtask

   task automatic test_random_settings();
      int thr;
      int deb;
      int tmo;
      int step;
      idle_on = 1'b1;
      for (int phase = 0; phase < 4; phase++) begin
         settle_pipeline();
         case ($urandom_range(0, 5))
            0:       thr = 1;
            1:       thr = 1023;
            default: thr = $urandom_range(50, 800);
         endcase
         deb  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                             : $urandom_range(0, 5000);
         tmo  = ($urandom_range(0, 9) < 7) ? $urandom_range(20000, 65535) : $urandom_range(0, 65535);
         step = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 20) : $urandom_range(0, 127);
         configure(thr, deb, tmo, step);
         stream_sequences(160);
      end
   endtask

   task automatic test_steady_stream();
      settle_pipeline();
      idle_on = 1'b0;
      configure(200, 1000, 30000, 5);
      stream_sequences(80);
      for (int k = 0; k < 10; k++) begin
         send_press(rand_stamp());
         send_tick(1'b1);
      end
      send_press({PRESS_W{1'b1}});
      send_tick(1'b1);
      send_press({PRESS_W{1'b1}});
      send_tick(1'b1);
   endtask

   always @(posedge clock) begin : status_check
      status_type got;
      status_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.mode         = rsp_mode;
         got.fault_lamp   = rsp_fault_lamp;
         got.active_lamp  = rsp_active_lamp;
         got.alarm_on     = rsp_alarm_on;
         got.range_cm     = rsp_range_cm;
         got.zone_fouled  = rsp_zone_fouled;
         got.servo_angle  = rsp_servo_angle;
         got.servo_duty   = rsp_servo_duty;
         got.duty_written = rsp_duty_written;
         if (status_queue.size() == 0) begin
            report_error($sformatf("status transfer with none pending: %s", show_status(got)));
         end else begin
            want = status_queue.pop_front();
            if (got !== want)
               report_error($sformatf("status %0d: got %s; want %s", responses_seen,
                                      show_status(got), show_status(want)));
         end
         responses_seen++;
         if (rsp_duty_written === 1'b1) servo_moves++;
         if (!$isunknown(rsp_mode)) mode_seen[rsp_mode]++;
      end
      if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
         stall_left = $urandom_range(1, 4);
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timed out after %0d cycles without a transfer.", STALL_LIMIT);
            $display("safety_interlock_sweep_controller_top_tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_power_on_status();
      test_lockout_sequence();
      test_register_extremes();
      test_random_settings();
      test_steady_stream();
      settle_pipeline();
      repeat (8) @(posedge clock);
      if (status_queue.size() != 0)
         report_error($sformatf("%0d status transfers never arrived", status_queue.size()));
      $display("Sent %0d requests under %0d register settings and checked %0d status transfers.",
               items_sent, settings_used + 1, responses_seen);
      $display("Servo moved %0d times; statuses in run/breach/arm-off/wait: %0d/%0d/%0d/%0d.",
               servo_moves, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
      if (error_count == 0) begin
         $display("safety_interlock_sweep_controller_top_tb: done, clean");
      end else begin
         $display("safety_interlock_sweep_controller_top_tb: done, errors");
      end
      $finish;
   end

endmodule
